/* rtl/bbm_pkg.sv */
// Shared types and constants for the billboard model matrix block.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package bbm_pkg;

  localparam int FRAC_BITS = 16;
  // width of a cosine or sine magnitude, 0..ONE
  localparam int CW = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic [2*CW-1:0] ONE_SQ = (2*CW)'(1) << (2 * FRAC_BITS);

  localparam int ROOT_W = 32;
  localparam int NUM_W = 32 + FRAC_BITS;

  localparam int QDEPTH = 8;
  localparam int QAW = $clog2(QDEPTH);
  localparam int FRONT_LAT = 3;

  typedef struct packed {
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic               up_normal;
    logic [15:0]        obj_scale;
  } item_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] tr_x;
    logic signed [31:0] tr_y;
    logic signed [31:0] tr_z;
  } result_t;

  typedef struct packed {
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
    logic               up_normal;
    logic [15:0]        obj_scale;
    logic               dx_neg;
    logic               dy_neg;
    logic               dz_pos;
    logic [30:0]        ay;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] sum_xy;
    logic [63:0] sum_l;
  } work_t;

  typedef struct packed {
    logic         empty;
    logic [QAW:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

/* rtl/bbm_isqrt.sv */
// Pipelined integer square root, one result bit per stage, 64-bit radicand.
// Depends on bbm_pkg.
`default_nettype none
module bbm_isqrt import bbm_pkg::*; (
  input  logic                clk,
  input  logic [63:0]         radicand,
  output logic [ROOT_W-1:0]   root
);

  logic [65:0]       rem [ROOT_W];
  logic [ROOT_W-1:0] res [ROOT_W+1];

  assign res[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    localparam int B = ROOT_W - 1 - k;
    logic [65:0] rin;
    logic [65:0] trial;
    logic        take_bit;
    if (k == 0) begin : g_first
      assign rin = {2'b00, radicand};
    end else begin : g_next
      assign rin = rem[k];
    end
    // rem holds radicand - res^2; try adding bit B to res
    assign trial = ({{(66-ROOT_W){1'b0}}, res[k]} << (B + 1)) + (66'd1 << (2 * B));
    assign take_bit = rin >= trial;
    always_ff @(posedge clk) begin
      res[k+1] <= take_bit ? (res[k] | (ROOT_W'(1) << B)) : res[k];
    end
    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k+1] <= take_bit ? rin - trial : rin;
      end
    end
  end

  assign root = res[ROOT_W];

endmodule
`default_nettype wire

/* rtl/bbm_div.sv */
// Pipelined restoring divider for ratios at most one: quotient of CW bits,
// one bit per stage. Depends on bbm_pkg.
`default_nettype none
module bbm_div import bbm_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic [CW-1:0]    quo
);

  logic [NUM_W:0]  rem [CW];
  logic [31:0]     dd  [CW];
  logic [CW-1:0]   qq  [CW+1];

  assign qq[0] = '0;

  for (genvar k = 0; k < CW; k++) begin : g_st
    localparam int B = CW - 1 - k;
    logic [NUM_W:0] rin;
    logic [31:0]    din;
    logic [NUM_W:0] trial;
    logic           take_bit;
    if (k == 0) begin : g_first
      assign rin = {1'b0, num};
      assign din = den;
    end else begin : g_next
      assign rin = rem[k];
      assign din = dd[k];
    end
    assign trial = {{(NUM_W-31){1'b0}}, din} << B;
    assign take_bit = rin >= trial;
    always_ff @(posedge clk) begin
      qq[k+1] <= take_bit ? (qq[k] | (CW'(1) << B)) : qq[k];
    end
    if (k < CW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k+1] <= take_bit ? rin - trial : rin;
        dd[k+1]  <= din;
      end
    end
  end

  assign quo = qq[CW];

endmodule
`default_nettype wire

/* rtl/bbm_front.sv */
// Front end: offset, magnitude, common shift and squares of one item.
// Depends on bbm_pkg.
`default_nettype none
module bbm_front import bbm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  output logic  valid,
  output work_t work
);

  logic signed [32:0] dx, dy, dz;
  logic [32:0]        mx, my, mz;
  logic               hi;

  logic        v1, v2;
  side_t       s1, s2;
  logic [30:0] ax1, az1;
  logic [61:0] qx, qy, qz;

  assign dx = {item.obj_x[31], item.obj_x} - {item.cam_x[31], item.cam_x};
  assign dy = {item.obj_y[31], item.obj_y} - {item.cam_y[31], item.cam_y};
  assign dz = {item.obj_z[31], item.obj_z} - {item.cam_z[31], item.cam_z};
  assign mx = dx[32] ? 33'(-dx) : 33'(dx);
  assign my = dy[32] ? 33'(-dy) : 33'(dy);
  assign mz = dz[32] ? 33'(-dz) : 33'(dz);
  // magnitudes stay below 2^32, so one shift at most brings all under 2^31
  assign hi = mx[31] | my[31] | mz[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= take;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s1.obj_x     <= item.obj_x;
    s1.obj_y     <= item.obj_y;
    s1.obj_z     <= item.obj_z;
    s1.up_normal <= item.up_normal;
    s1.obj_scale <= item.obj_scale;
    s1.dx_neg    <= dx[32];
    s1.dy_neg    <= dy[32];
    s1.dz_pos    <= !dz[32] && (dz != '0);
    s1.ay        <= hi ? my[31:1] : my[30:0];
    ax1          <= hi ? mx[31:1] : mx[30:0];
    az1          <= hi ? mz[31:1] : mz[30:0];

    s2 <= s1;
    qx <= ax1 * ax1;
    qy <= s1.ay * s1.ay;
    qz <= az1 * az1;

    work.side   <= s2;
    work.sum_xy <= 64'(qx) + 64'(qy);
    work.sum_l  <= 64'(qx) + 64'(qy) + 64'(qz);
  end

endmodule
`default_nettype wire

/* rtl/bbm_queue.sv */
// Small FIFO that decouples the front end from the back end.
// Depends on bbm_pkg.
`default_nettype none
module bbm_queue import bbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  work_t   wdata,
  input  logic    pop,
  output work_t   rdata,
  output q_stat_t stat
);

  work_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  assign rdata      = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule
`default_nettype wire

/* rtl/bbm_back.sv */
// Back end: roots, angle ratios, sines, matrix products and scaling.
// Depends on bbm_pkg, bbm_isqrt and bbm_div.
`default_nettype none
module bbm_back import bbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    valid,
  input  work_t   work,
  output logic    done,
  output result_t result
);

  typedef struct packed {
    side_t side;
    logic  lxy_zero;
    logic  l_zero;
  } dside_t;

  localparam int LAT = 2 * ROOT_W + CW + 5;

  logic [LAT-1:0] vpipe;

  // roots of the horizontal and full squared lengths
  logic [ROOT_W-1:0] lxy, l;
  side_t             da [ROOT_W];
  bbm_isqrt u_rt_xy (.clk(clk), .radicand(work.sum_xy), .root(lxy));
  bbm_isqrt u_rt_l  (.clk(clk), .radicand(work.sum_l),  .root(l));

  // cosines as ratios
  logic [CW-1:0] qv, qh;
  dside_t        db [CW];
  bbm_div u_div_v (.clk(clk), .num({lxy, {FRAC_BITS{1'b0}}}), .den(l), .quo(qv));
  bbm_div u_div_h (.clk(clk), .num({1'b0, da[ROOT_W-1].ay, {FRAC_BITS{1'b0}}}),
                   .den(lxy), .quo(qh));

  logic [CW-1:0]   cvm_e, chm_e, cvm_f, chm_f;
  logic [2*CW-1:0] sqv_e, sqh_e;
  side_t           side_d, side_e, side_f;
  logic [63:0]     arg_v, arg_h;
  logic [CW-1:0]   cv_sel, ch_sel;

  // sines
  logic [ROOT_W-1:0] rsv, rsh;
  logic [CW-1:0]     dcv [ROOT_W];
  logic [CW-1:0]     dch [ROOT_W];
  side_t             dc  [ROOT_W];
  bbm_isqrt u_rt_sv (.clk(clk), .radicand(arg_v), .root(rsv));
  bbm_isqrt u_rt_sh (.clk(clk), .radicand(arg_h), .root(rsh));

  logic [CW-1:0] cvm, chm, svm, shm;
  logic          cv_n, ch_n, sh_n, sv_n;

  logic [CW-1:0]   g_cv, g_ch, g_sv, g_sh;
  logic            g_cvn, g_chn, g_svn, g_shn;
  logic [2*CW-1:0] p_vs, p_vh, p_ss, p_sh;
  side_t           side_g;

  logic [CW-1:0]    r_vs, r_vh, r_ss, r_sh;
  logic [CW-1:0]    emag [9];
  logic             eneg [9];
  logic [CW-1:0]    h_mag [9];
  logic             h_neg [9];
  logic [CW+15:0]   h_prod [9];
  logic             h_noscale;
  side_t            side_h;
  logic signed [31:0] mout [9];

  function automatic logic [CW-1:0] round_q(input logic [2*CW-1:0] p);
    logic [2*CW-1:0] s;
    s = (p + ((2*CW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return s[CW-1:0];
  endfunction

  function automatic logic signed [31:0] finish(input logic [CW-1:0] m,
                                                input logic [CW+15:0] pr,
                                                input logic neg, input logic noscale);
    logic [63:0] p;
    p = noscale ? 64'(m) : ((64'(pr) + 64'd128) >> 8);
    if (neg) begin
      if (p > 64'h8000_0000) p = 64'h8000_0000;
      return -$signed(p[31:0]);
    end
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    return $signed(p[31:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], valid};
    end
  end
  assign done = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    da[0] <= work.side;
    for (int i = 1; i < ROOT_W; i++) da[i] <= da[i-1];
    db[0] <= '{side: da[ROOT_W-1], lxy_zero: (lxy == '0), l_zero: (l == '0)};
    for (int i = 1; i < CW; i++) db[i] <= db[i-1];
  end

  // object at camera or on the vertical axis: fall back to fixed directions
  assign cv_sel = db[CW-1].l_zero   ? ONE : ((qv > ONE) ? ONE : qv);
  assign ch_sel = db[CW-1].lxy_zero ? ONE : ((qh > ONE) ? ONE : qh);

  // the fixed horizontal direction carries no sign from dy
  always_comb begin
    side_d        = db[CW-1].side;
    side_d.dy_neg = db[CW-1].side.dy_neg && !db[CW-1].lxy_zero;
  end

  always_ff @(posedge clk) begin
    cvm_e  <= cv_sel;
    chm_e  <= ch_sel;
    sqv_e  <= cv_sel * cv_sel;
    sqh_e  <= ch_sel * ch_sel;
    side_e <= side_d;

    // clamp 1 - cos^2 at zero
    arg_v  <= (sqv_e >= ONE_SQ) ? 64'd0 : 64'(ONE_SQ - sqv_e);
    arg_h  <= (sqh_e >= ONE_SQ) ? 64'd0 : 64'(ONE_SQ - sqh_e);
    cvm_f  <= cvm_e;
    chm_f  <= chm_e;
    side_f <= side_e;

    dcv[0] <= cvm_f;
    dch[0] <= chm_f;
    dc[0]  <= side_f;
    for (int i = 1; i < ROOT_W; i++) begin
      dcv[i] <= dcv[i-1];
      dch[i] <= dch[i-1];
      dc[i]  <= dc[i-1];
    end
  end

  assign cvm  = dcv[ROOT_W-1];
  assign chm  = dch[ROOT_W-1];
  assign svm  = rsv[CW-1:0];
  assign shm  = rsh[CW-1:0];
  // sign flags count only for nonzero magnitudes
  assign cv_n = !dc[ROOT_W-1].up_normal && (cvm != '0);
  assign ch_n = (dc[ROOT_W-1].dy_neg ^ !dc[ROOT_W-1].up_normal) && (chm != '0)
                && !(dc[ROOT_W-1].dy_neg && !dc[ROOT_W-1].up_normal);
  assign sh_n = (dc[ROOT_W-1].dx_neg ^ !dc[ROOT_W-1].up_normal) && (shm != '0);
  assign sv_n = dc[ROOT_W-1].dz_pos && (svm != '0);

  always_ff @(posedge clk) begin
    g_cv   <= cvm;  g_ch  <= chm;  g_sv  <= svm;  g_sh  <= shm;
    g_cvn  <= cv_n; g_chn <= ch_n; g_svn <= sv_n; g_shn <= sh_n;
    p_vs   <= cvm * shm;
    p_vh   <= cvm * chm;
    p_ss   <= svm * shm;
    p_sh   <= svm * chm;
    side_g <= dc[ROOT_W-1];
  end

  assign r_vs = round_q(p_vs);
  assign r_vh = round_q(p_vh);
  assign r_ss = round_q(p_ss);
  assign r_sh = round_q(p_sh);

  always_comb begin
    emag[0] = g_ch;  eneg[0] = g_chn;
    emag[1] = g_sh;  eneg[1] = !g_shn && (g_sh != '0);
    emag[2] = '0;    eneg[2] = 1'b0;
    emag[3] = r_vs;  eneg[3] = (g_cvn ^ g_shn) && (r_vs != '0);
    emag[4] = r_vh;  eneg[4] = (g_cvn ^ g_chn) && (r_vh != '0);
    emag[5] = g_sv;  eneg[5] = !g_svn && (g_sv != '0);
    emag[6] = r_ss;  eneg[6] = (g_svn ^ g_shn) && (r_ss != '0);
    emag[7] = r_sh;  eneg[7] = (g_svn ^ g_chn) && (r_sh != '0);
    emag[8] = g_cv;  eneg[8] = g_cvn;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      h_mag[i]  <= emag[i];
      h_neg[i]  <= eneg[i];
      h_prod[i] <= emag[i] * side_g.obj_scale;
    end
    h_noscale <= (side_g.obj_scale == '0);
    side_h    <= side_g;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mout[i] = finish(h_mag[i], h_prod[i], h_neg[i], h_noscale);
    end
  end

  always_ff @(posedge clk) begin
    result.m00  <= mout[0];
    result.m01  <= mout[1];
    result.m02  <= mout[2];
    result.m10  <= mout[3];
    result.m11  <= mout[4];
    result.m12  <= mout[5];
    result.m20  <= mout[6];
    result.m21  <= mout[7];
    result.m22  <= mout[8];
    result.tr_x <= side_h.obj_x;
    result.tr_y <= side_h.obj_y;
    result.tr_z <= side_h.obj_z;
  end

endmodule
`default_nettype wire

/* rtl/billboard_model_matrix.sv */
// Billboard model matrix: from accepted start to done an item passes the
// front end, the queue, two bit-serial square-root pipelines and the ratio
// divider pipeline. Throughput is one item per cycle while busy is low;
// the result is presented for one cycle under done. Synchronous reset clears
// the queue and all valid flags.
`default_nettype none
module billboard_model_matrix import bbm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic    f_valid;
  work_t   f_work;
  work_t   q_data;
  q_stat_t q_stat;
  logic    q_pop;

  bbm_front u_front (
    .clk(clk), .rst(rst), .take(start && !busy), .item(item),
    .valid(f_valid), .work(f_work)
  );

  bbm_queue u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .wdata(f_work),
    .pop(q_pop), .rdata(q_data), .stat(q_stat)
  );

  // the back end never stalls, so drain a beat whenever one is queued
  assign q_pop = !q_stat.empty;

  bbm_back u_back (
    .clk(clk), .rst(rst), .valid(q_pop), .work(q_data),
    .done(done), .result(result)
  );

  // leave room for beats still in the front end
  assign busy = (q_stat.count >= (QAW+1)'(QDEPTH - FRONT_LAT));

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(f_valid && !q_pop && q_stat.count == (QAW+1)'(QDEPTH)))
    else $error("queue overflow");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("back end fell behind");

  a_m02_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.m02 == '0))
    else $error("m02 not zero");

endmodule
`default_nettype wire

/* tb/tb_billboard_model_matrix.sv */
// Testbench for billboard_model_matrix: random and directed object/camera beats,
// a bit-exact predictor and an in-order scoreboard. Depends on all rtl/ files.
module tb_billboard_model_matrix;
  timeunit 1ns;
  timeprecision 1ps;
  import bbm_pkg::*;

  localparam longint QONE = 64'sd1 << FRAC_BITS;

  class matrix_scoreboard;
    result_t pending[$];
    int      mismatches;
    int      checked;

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    static function longint fx_mul(longint a, longint b);
      longint unsigned p;
      longint r;
      p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
      r = longint'((p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    static function longint sine_of(longint c);
      longint unsigned c2;
      longint unsigned one2;
      one2 = 64'd1 << (2 * FRAC_BITS);
      c2 = longint'(c < 0 ? -c : c) * longint'(c < 0 ? -c : c);
      return longint'(int_sqrt(c2 >= one2 ? 0 : one2 - c2));
    endfunction

    static function longint scale_sat(longint v, longint unsigned s);
      longint unsigned p;
      p = (longint'(v < 0 ? -v : v) * s + 128) >> 8;
      if (v < 0) begin
        if (p > 64'h8000_0000) p = 64'h8000_0000;
        return -longint'(p);
      end
      if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
      return longint'(p);
    endfunction

    static function result_t billboard_matrix(item_t it);
      longint dx, dy, dz, cv, sv, ch, sh;
      longint unsigned ax, ay, az, lxy, len;
      longint m[9];
      result_t r;
      dx = longint'(it.obj_x) - longint'(it.cam_x);
      dy = longint'(it.obj_y) - longint'(it.cam_y);
      dz = longint'(it.obj_z) - longint'(it.cam_z);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      // keep ratios: shift all three until each fits in 31 bits
      while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000 || az >= 64'h8000_0000) begin
        ax >>= 1;
        ay >>= 1;
        az >>= 1;
      end
      lxy = int_sqrt(ax * ax + ay * ay);
      len = int_sqrt(ax * ax + ay * ay + az * az);
      if (len == 0) cv = QONE;
      else begin
        cv = longint'((lxy << FRAC_BITS) / len);
        if (cv > QONE) cv = QONE;
      end
      sv = sine_of(cv);
      if (dz > 0) sv = -sv;
      if (lxy == 0) ch = QONE;
      else begin
        ch = longint'((ay << FRAC_BITS) / lxy);
        if (ch > QONE) ch = QONE;
        if (dy < 0) ch = -ch;
      end
      sh = sine_of(ch);
      if (dx < 0) sh = -sh;
      if (!it.up_normal) begin
        cv = -cv;
        ch = -ch;
        sh = -sh;
      end
      m[0] = ch;             m[1] = -sh;            m[2] = 0;
      m[3] = fx_mul(cv, sh); m[4] = fx_mul(cv, ch); m[5] = -sv;
      m[6] = fx_mul(sv, sh); m[7] = fx_mul(sv, ch); m[8] = cv;
      if (it.obj_scale != 0)
        foreach (m[i]) m[i] = scale_sat(m[i], it.obj_scale);
      r.m00 = m[0][31:0]; r.m01 = m[1][31:0]; r.m02 = m[2][31:0];
      r.m10 = m[3][31:0]; r.m11 = m[4][31:0]; r.m12 = m[5][31:0];
      r.m20 = m[6][31:0]; r.m21 = m[7][31:0]; r.m22 = m[8][31:0];
      r.tr_x = it.obj_x; r.tr_y = it.obj_y; r.tr_z = it.obj_z;
      return r;
    endfunction

    function void note_item(item_t it);
      pending.push_back(billboard_matrix(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.m00 !== want.m00) report_mismatch("m00", got.m00, want.m00);
      if (got.m01 !== want.m01) report_mismatch("m01", got.m01, want.m01);
      if (got.m02 !== want.m02) report_mismatch("m02", got.m02, want.m02);
      if (got.m10 !== want.m10) report_mismatch("m10", got.m10, want.m10);
      if (got.m11 !== want.m11) report_mismatch("m11", got.m11, want.m11);
      if (got.m12 !== want.m12) report_mismatch("m12", got.m12, want.m12);
      if (got.m20 !== want.m20) report_mismatch("m20", got.m20, want.m20);
      if (got.m21 !== want.m21) report_mismatch("m21", got.m21, want.m21);
      if (got.m22 !== want.m22) report_mismatch("m22", got.m22, want.m22);
      if (got.tr_x !== want.tr_x) report_mismatch("tr_x", got.tr_x, want.tr_x);
      if (got.tr_y !== want.tr_y) report_mismatch("tr_y", got.tr_y, want.tr_y);
      if (got.tr_z !== want.tr_z) report_mismatch("tr_z", got.tr_z, want.tr_z);
    endfunction

    function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("MISMATCH beat %0d %s: got %h want %h", checked, what, got, want);
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;

  matrix_scoreboard sb;
  bit  idle_on;
  int  sent;

  billboard_model_matrix u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // hold the beat until it is taken
  task automatic send_beat(item_t it);
    if (idle_on) begin
      while ($urandom_range(99) < 34) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      3: return 32'($signed($urandom_range(200)) - 100) <<< 16;
      default: return 32'($signed($urandom_range(2_000_000)) - 1_000_000);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.obj_x = rand_coord(); it.obj_y = rand_coord(); it.obj_z = rand_coord();
    case ($urandom_range(5))
      0: begin
        it.cam_x = it.obj_x; it.cam_y = it.obj_y; it.cam_z = rand_coord();
      end
      1: begin
        it.cam_x = it.obj_x; it.cam_y = rand_coord(); it.cam_z = rand_coord();
      end
      2: begin
        it.cam_x = rand_coord(); it.cam_y = it.obj_y; it.cam_z = it.obj_z;
      end
      default: begin
        it.cam_x = rand_coord(); it.cam_y = rand_coord(); it.cam_z = rand_coord();
      end
    endcase
    it.up_normal = $urandom_range(1);
    case ($urandom_range(3))
      0: it.obj_scale = 16'h0000;
      1: it.obj_scale = 16'h0100;
      2: it.obj_scale = 16'hFFFF - $urandom_range(1);
      default: it.obj_scale = $urandom;
    endcase
    return it;
  endfunction

  function automatic item_t make_item(logic [31:0] px, py, pz, cx, cy, cz,
                                      logic up, logic [15:0] s);
    item_t it;
    it.obj_x = px; it.obj_y = py; it.obj_z = pz;
    it.cam_x = cx; it.cam_y = cy; it.cam_z = cz;
    it.up_normal = up; it.obj_scale = s;
    return it;
  endfunction

  initial begin
    int wait_cycles;
    sb = new();
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    idle_on = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // object at camera, zero horizontal projection, axis directions, extremes
    send_beat(make_item(0, 0, 0, 0, 0, 0, 1, 0));
    send_beat(make_item(0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    send_beat(make_item(0, 0, 32'h0001_0000, 0, 0, 0, 1, 0));
    send_beat(make_item(0, 0, 32'hFFFF_0000, 0, 0, 0, 0, 16'h0100));
    send_beat(make_item(32'h0001_0000, 0, 0, 0, 0, 0, 1, 0));
    send_beat(make_item(32'hFFFF_0000, 0, 0, 0, 0, 0, 1, 16'h0080));
    send_beat(make_item(0, 32'h0001_0000, 0, 0, 0, 0, 1, 16'hFFFF));
    send_beat(make_item(0, 32'hFFFF_0000, 0, 0, 0, 0, 0, 16'h0001));
    send_beat(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 16'hFFFF));
    send_beat(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'hFFFF));
    send_beat(make_item(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0,
                        32'h7FFF_FFFF, 1, 16'h8000));
    send_beat(make_item(1, 1, 1, 0, 0, 0, 1, 0));
    send_beat(make_item(1, 1, 0, 0, 0, 0, 0, 16'h0200));
    send_beat(make_item(32'h0003_0000, 32'h0004_0000, 32'h000C_0000, 0, 0, 0, 1, 16'h0180));
    send_beat(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'h5555));

    // back to back for a stretch, then random gaps
    for (int i = 0; i < 540; i++) begin
      idle_on = (i >= 150);
      if (i == 300) begin
        // drain fully before resuming
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_beat(rand_item());
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * 32 + FRAC_BITS + 20) @(posedge clk);

    $display("Checked %0d matrices from %0d beats: directed corners, both up flags,",
             sb.checked, sent);
    $display("scale zero to full range, degenerate offsets, gaps and back-to-back.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/bbm_pkg.sv
rtl/bbm_isqrt.sv
rtl/bbm_div.sv
rtl/bbm_front.sv
rtl/bbm_queue.sv
rtl/bbm_back.sv
rtl/billboard_model_matrix.sv
tb/tb_billboard_model_matrix.sv
